// File: hdl/kest_pkg.sv
// ----------------------------------------------------------------------------
// kest_pkg: shared types and codes for the edge select/toggle block
// Operation and status codes, payload structs and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package kest_pkg;

	localparam int MAX_NODES_DEF = 64;

	localparam int OP_W     = 2;
	localparam int RANK_W   = 11;
	localparam int NODE_W   = 6;
	localparam int STATUS_W = 2;
	localparam int EDGE_W   = 11;
	localparam int NC_W     = 7;

	localparam logic [NC_W-1:0] NODE_COUNT_RST = 7'd64;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_DEL = 2'd1;
	localparam logic [OP_W-1:0] OP_SET = 2'd2;
	localparam logic [OP_W-1:0] OP_CLR = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANK = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PAIR = 2'd2;

	// row read address select
	localparam logic [1:0] RD_SCAN = 2'd0;
	localparam logic [1:0] RD_TGT  = 2'd1;
	localparam logic [1:0] RD_PAIR = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [RANK_W-1:0] rank;
		logic [NODE_W-1:0] row_in;
		logic [NODE_W-1:0] col_in;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0]   row_out;
		logic [NODE_W-1:0]   col_out;
		logic [STATUS_W-1:0] status;
		logic [EDGE_W-1:0]   edges_now;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       fetch;
		logic       sel_step;
		logic       wr_en;
		logic       fail_rank;
		logic       fail_pair;
	} cmd_t;

	typedef struct packed {
		logic is_scan;
		logic pair_ok;
		logic scan_last;
		logic rank_ok;
		logic sel_hit;
	} stat_t;

endpackage

// File: hdl/kest_ram.sv
// ----------------------------------------------------------------------------
// kest_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kest_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/kest_datapath.sv
// ----------------------------------------------------------------------------
// kest_datapath: edge bitmap store, scan counters and pair selection
// Holds the row memory with per-row valid bits, the node count register,
// the two-stage row popcount, the rank search and the in-row select unit.
// ----------------------------------------------------------------------------
module kest_datapath #(
	parameter int MAX_NODES = kest_pkg::MAX_NODES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kest_pkg::NC_W-1:0]       cfg_data,
	input  kest_pkg::item_t                 item,
	input  kest_pkg::cmd_t                  cmd,
	output kest_pkg::stat_t                 stat,
	output kest_pkg::result_t               result
);

	localparam int IW  = $clog2(MAX_NODES);
	localparam int NW  = $clog2(MAX_NODES + 1);
	localparam int CW  = $clog2(MAX_NODES * (MAX_NODES - 1) / 2 + 1);
	localparam int SW  = ((CW > kest_pkg::RANK_W) ? CW : kest_pkg::RANK_W) + 1;
	localparam int CH  = (MAX_NODES + 7) / 8;
	localparam int NCH = (MAX_NODES + CH - 1) / CH;
	localparam int PW  = NCH * CH;
	localparam int CHW = $clog2(CH + 1);

	function automatic logic [CHW-1:0] chunk_pop(input logic [CH-1:0] bits);
		logic [CHW-1:0] acc;
		acc = '0;
		for (int j = 0; j < CH; j++) begin
			acc = acc + CHW'(bits[j]);
		end
		return acc;
	endfunction

	logic [kest_pkg::NC_W-1:0] node_count_q;
	kest_pkg::item_t           item_q;
	logic [NW-1:0]             n_w;

	logic [MAX_NODES-1:0] valid_q;
	logic [IW-1:0]        scan_q;
	logic [IW-1:0]        raddr;
	logic [MAX_NODES-1:0] rdata;
	logic [MAX_NODES-1:0] wdata;

	logic                 vld_s1;
	logic                 scan_pend_s1;
	logic [IW-1:0]        rd_row_s1;
	logic [MAX_NODES-1:0] row_data;
	logic [MAX_NODES-1:0] row_mask;
	logic [PW-1:0]        sel_pad;
	logic                 want;

	logic [CHW-1:0] cnt_s2 [NCH];
	logic           pend_s2;
	logic [IW-1:0]  row_s2;
	logic [NW-1:0]  row_pop;

	logic [CW-1:0] seen_q;
	logic          found_q;
	logic [IW-1:0] tgt_row_q;
	logic [NW-1:0] k_q;
	logic [SW-1:0] rank_diff;

	logic [MAX_NODES-1:0] raw_q;
	logic [PW-1:0]        word_q;
	logic [IW-1:0]        base_q;
	logic                 bitph_q;
	logic [CHW-1:0]       chunk_p;

	logic [IW-1:0] row_q;
	logic [IW-1:0] col_q;
	logic [CW-1:0] count_q;
	logic [kest_pkg::STATUS_W-1:0] status_q;

	logic [kest_pkg::NODE_W-1:0] pair_lo6;
	logic [kest_pkg::NODE_W-1:0] pair_hi6;
	logic                        new_bit;

	logic [IW+kest_pkg::NODE_W-1:0] row_ext;
	logic [IW+kest_pkg::NODE_W-1:0] col_ext;
	logic [CW+kest_pkg::EDGE_W-1:0] edge_ext;

	// effective node count, clamped to 2..MAX_NODES
	always_comb begin
		if (int'(node_count_q) < 2) begin
			n_w = NW'(2);
		end else if (int'(node_count_q) > MAX_NODES) begin
			n_w = NW'(MAX_NODES);
		end else begin
			n_w = NW'(node_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= kest_pkg::NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_data;
		end
	end

	assign want    = (item_q.op == kest_pkg::OP_DEL);
	assign new_bit = (item_q.op == kest_pkg::OP_ADD) || (item_q.op == kest_pkg::OP_SET);

	assign pair_lo6 = (item_q.row_in < item_q.col_in) ? item_q.row_in : item_q.col_in;
	assign pair_hi6 = (item_q.row_in < item_q.col_in) ? item_q.col_in : item_q.row_in;

	always_comb begin
		unique case (cmd.rd_sel)
			kest_pkg::RD_SCAN: raddr = scan_q;
			kest_pkg::RD_TGT:  raddr = tgt_row_q;
			default:           raddr = IW'(pair_lo6);
		endcase
	end

	// row memory, one bit per column
	always_comb begin
		wdata = raw_q;
		wdata[col_q] = new_bit;
	end

	kest_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_rows (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(row_q),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// a row never written reads as empty
	assign row_data = vld_s1 ? rdata : '0;

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			row_mask[i] = (i > int'(rd_row_s1)) && (i < int'(n_w));
		end
		sel_pad = '0;
		sel_pad[MAX_NODES-1:0] = (want ? row_data : ~row_data) & row_mask;
	end

	always_comb begin
		row_pop = '0;
		for (int c = 0; c < NCH; c++) begin
			row_pop = row_pop + NW'(cnt_s2[c]);
		end
	end

	assign chunk_p   = chunk_pop(word_q[CH-1:0]);
	assign rank_diff = SW'(item_q.rank) - SW'(seen_q);

	// read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			vld_s1       <= 1'b0;
			scan_pend_s1 <= 1'b0;
			pend_s2      <= 1'b0;
		end else begin
			vld_s1       <= cmd.rd_en && valid_q[raddr];
			scan_pend_s1 <= cmd.rd_en && (cmd.rd_sel == kest_pkg::RD_SCAN);
			pend_s2      <= scan_pend_s1;
			if (cmd.wr_en) begin
				valid_q[row_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_row_s1 <= raddr;
		row_s2    <= rd_row_s1;
		for (int c = 0; c < NCH; c++) begin
			cnt_s2[c] <= chunk_pop(sel_pad[c*CH +: CH]);
		end
	end

	// search and write state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			seen_q   <= '0;
			found_q  <= 1'b0;
			count_q  <= '0;
			status_q <= kest_pkg::ST_OK;
			bitph_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q  <= '0;
				seen_q  <= '0;
				found_q <= 1'b0;
			end
			if (cmd.rd_en && (cmd.rd_sel == kest_pkg::RD_SCAN)) begin
				scan_q <= scan_q + IW'(1);
			end
			if (pend_s2) begin
				seen_q <= seen_q + CW'(row_pop);
				if (!found_q && (item_q.rank != '0)
						&& (SW'(seen_q) + SW'(row_pop) >= SW'(item_q.rank))) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.fetch) begin
				bitph_q <= 1'b0;
			end else if (cmd.sel_step && !bitph_q && !(k_q > NW'(chunk_p))) begin
				bitph_q <= 1'b1;
			end
			if (cmd.fail_rank) begin
				status_q <= kest_pkg::ST_RANK;
			end else if (cmd.fail_pair) begin
				status_q <= kest_pkg::ST_PAIR;
			end else if (cmd.wr_en) begin
				status_q <= kest_pkg::ST_OK;
				if (raw_q[col_q] != new_bit) begin
					count_q <= new_bit ? count_q + CW'(1) : count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (pend_s2 && !found_q && (item_q.rank != '0)
				&& (SW'(seen_q) + SW'(row_pop) >= SW'(item_q.rank))) begin
			tgt_row_q <= row_s2;
			k_q       <= NW'(rank_diff);
		end
		if (cmd.rd_en && (cmd.rd_sel != kest_pkg::RD_SCAN)) begin
			row_q <= raddr;
		end
		if (cmd.rd_en && (cmd.rd_sel == kest_pkg::RD_PAIR)) begin
			col_q <= IW'(pair_hi6);
		end
		if (cmd.fetch) begin
			raw_q  <= row_data;
			word_q <= sel_pad;
			base_q <= '0;
		end else if (cmd.sel_step) begin
			if (!bitph_q) begin
				// skip whole chunks that hold fewer candidates than remain
				if (k_q > NW'(chunk_p)) begin
					k_q    <= k_q - NW'(chunk_p);
					word_q <= word_q >> CH;
					base_q <= base_q + IW'(CH);
				end
			end else if (stat.sel_hit) begin
				col_q <= base_q;
			end else begin
				if (word_q[0]) begin
					k_q <= k_q - NW'(1);
				end
				word_q <= word_q >> 1;
				base_q <= base_q + IW'(1);
			end
		end
	end

	assign stat.is_scan   = (item_q.op == kest_pkg::OP_ADD) || (item_q.op == kest_pkg::OP_DEL);
	assign stat.pair_ok   = (item_q.row_in != item_q.col_in)
		&& (int'(item_q.row_in) < int'(n_w)) && (int'(item_q.col_in) < int'(n_w));
	assign stat.scan_last = (int'(scan_q) == int'(n_w) - 2);
	assign stat.rank_ok   = (item_q.rank != '0) && (SW'(item_q.rank) <= SW'(seen_q));
	assign stat.sel_hit   = bitph_q && word_q[0] && (k_q == NW'(1));

	assign row_ext  = {{kest_pkg::NODE_W{1'b0}}, row_q};
	assign col_ext  = {{kest_pkg::NODE_W{1'b0}}, col_q};
	assign edge_ext = {{kest_pkg::EDGE_W{1'b0}}, count_q};

	assign result.row_out   = (status_q == kest_pkg::ST_OK) ? row_ext[kest_pkg::NODE_W-1:0] : '0;
	assign result.col_out   = (status_q == kest_pkg::ST_OK) ? col_ext[kest_pkg::NODE_W-1:0] : '0;
	assign result.status    = status_q;
	assign result.edges_now = edge_ext[kest_pkg::EDGE_W-1:0];

`ifndef ASSERT_OFF
	a_sel_rank_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_step |-> (k_q != '0))
		else $error("select step with no rank left");

	a_sel_word_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_step |-> (word_q != '0))
		else $error("select step over an empty word");

	a_scan_flips: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && stat.is_scan) |-> (raw_q[col_q] != new_bit))
		else $error("ranked pick landed on a pair already in the wanted state");
`endif

endmodule

// File: hdl/kest_ctrl.sv
// ----------------------------------------------------------------------------
// kest_ctrl: sequencing state machine
// Steps one operation through decode, row scan and rank check (ranked ops),
// row fetch, in-row select (ranked ops), write-back and the result beat.
// ----------------------------------------------------------------------------
module kest_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  kest_pkg::stat_t stat,
	output kest_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_DRAIN1 = 4'd3;
	localparam logic [3:0] S_DRAIN2 = 4'd4;
	localparam logic [3:0] S_CHECK  = 4'd5;
	localparam logic [3:0] S_FETCH  = 4'd6;
	localparam logic [3:0] S_SEL    = 4'd7;
	localparam logic [3:0] S_WRITE  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_scan) begin
					state_nx = S_SCAN;
				end else if (stat.pair_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = kest_pkg::RD_PAIR;
					state_nx   = S_FETCH;
				end else begin
					cmd.fail_pair = 1'b1;
					state_nx      = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = kest_pkg::RD_SCAN;
				if (stat.scan_last) begin
					state_nx = S_DRAIN1;
				end
			end
			// let the last row's count reach the accumulator
			S_DRAIN1: state_nx = S_DRAIN2;
			S_DRAIN2: state_nx = S_CHECK;
			S_CHECK: begin
				if (stat.rank_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = kest_pkg::RD_TGT;
					state_nx   = S_FETCH;
				end else begin
					cmd.fail_rank = 1'b1;
					state_nx      = S_DONE;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_nx  = stat.is_scan ? S_SEL : S_WRITE;
			end
			S_SEL: begin
				cmd.sel_step = 1'b1;
				if (stat.sel_hit) begin
					state_nx = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.wr_en = 1'b1;
				state_nx  = S_DONE;
			end
			S_DONE: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat held for more than one cycle");

	a_write_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> ($past(state_q) == S_FETCH || $past(state_q) == S_SEL))
		else $error("row written without a fresh fetch");
`endif

endmodule

// File: hdl/kth_edge_select_toggle.sv
// ----------------------------------------------------------------------------
// kth_edge_select_toggle: ranked add/delete, set/clear on an undirected graph
// Keeps the upper-triangle edge bitmap and the running edge count.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (op, rank, row_in, col_in) is taken at a rising
//   edge with start high and busy low. busy stays high until the result beat.
//   Result channel: done is high for exactly one cycle with result valid;
//   there is no back-pressure, so the receiver must take the beat then.
//   Configuration: cfg_we writes node_count from cfg_data; write only while
//   busy is low.
//   Paths from acceptance to done:
//     set/clear pair: decode, row fetch, write-back (a bad pair ends at
//     decode); ranked add/delete: decode, row scan, rank check, row fetch,
//     in-row select, write-back; a rank out of range ends at the rank check.
//   The row scan reads one row of the bitmap memory per cycle; busy drops
//   after each result beat.
//   Reset clears the graph at once through per-row valid bits, zeroes the
//   edge count and sets node_count to 64.
// ----------------------------------------------------------------------------
module kth_edge_select_toggle #(
	parameter int MAX_NODES = kest_pkg::MAX_NODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  kest_pkg::item_t           item,
	output logic                      done,
	output kest_pkg::result_t         result,
	input  logic                      cfg_we,
	input  logic [kest_pkg::NC_W-1:0] cfg_data
);

	kest_pkg::cmd_t  cmd;
	kest_pkg::stat_t stat;

	kest_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	kest_datapath #(
		.MAX_NODES(MAX_NODES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.item    (item),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule
